/* design/pba_pkg.sv */
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int WORD_BITS  = 32;
	localparam int BIT_W      = 5;
	localparam int CFG_W      = 32;
	localparam int RES_W      = 13;
	localparam int ADDR_OUT_W = 25;
	localparam int CNT_W      = 14;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;
	localparam int ACT_W      = 2;
	localparam int REG_IDX_W  = 2;

	localparam logic [RES_W-1:0] RES_FIRST_RST = 13'h0A0;
	localparam logic [RES_W-1:0] RES_LAST_RST  = 13'h0BF;

	typedef enum logic [ACT_W-1:0] {
		ACT_INIT    = 2'd0,
		ACT_ALLOC   = 2'd1,
		ACT_RELEASE = 2'd2
	} action_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KERNEL_END = 2'd0,
		REG_RES_FIRST  = 2'd1,
		REG_RES_LAST   = 2'd2
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND1,
		ST_FIND2,
		ST_READ,
		ST_MODIFY,
		ST_NOP,
		ST_INIT_LO,
		ST_INIT_WIN,
		ST_INIT_SWEEP
	} state_t;

	typedef struct packed {
		logic we;
		logic re;
	} ram_ctl_t;

	typedef struct packed {
		logic en;
		logic has_free;
	} sum_upd_t;

endpackage

/* design/pba_bitmap_ram.sv */
// ----------------------------------------------------------------------------
// pba_bitmap_ram
// Word-wide used/free bitmap store, one write and one registered read port.
// ----------------------------------------------------------------------------
module pba_bitmap_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                       clk,
	input  pba_pkg::ram_ctl_t          ctl,
	input  logic [AW-1:0]              waddr,
	input  logic [pba_pkg::WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [pba_pkg::WORD_BITS-1:0] rdata
);
	import pba_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/pba_free_search.sv */
// ----------------------------------------------------------------------------
// pba_free_search
// Per-word "has a free page" summary with a two-level lowest-word search.
// ----------------------------------------------------------------------------
module pba_free_search #(
	parameter int NUM_WORDS = 256,
	parameter int WAW       = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pba_pkg::sum_upd_t upd,
	input  logic [WAW-1:0]    upd_idx,
	input  logic              step,
	output logic              any_free,
	output logic [WAW-1:0]    word_idx
);
	import pba_pkg::*;

	localparam int GROUP      = (NUM_WORDS < 16) ? NUM_WORDS : 16;
	localparam int NUM_GROUPS = NUM_WORDS / GROUP;
	localparam int GAW        = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int SAW        = $clog2(GROUP);

	logic [NUM_WORDS-1:0]  summary_q;
	logic [NUM_GROUPS-1:0] grp_or;
	logic [GAW-1:0]        grp_sel;
	logic [GAW-1:0]        grp_q;
	logic                  any_q;
	logic [GROUP-1:0]      grp_bits;
	logic [SAW-1:0]        sub_sel;

	always_comb begin
		grp_sel = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_or[g] = |summary_q[g*GROUP +: GROUP];
		end
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_or[g]) begin
				grp_sel = GAW'(g);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_q <= '1;
			grp_q     <= '0;
			any_q     <= 1'b0;
		end else begin
			if (upd.en) begin
				summary_q[upd_idx] <= upd.has_free;
			end
			if (step) begin
				grp_q <= grp_sel;
				any_q <= |grp_or;
			end
		end
	end

	always_comb begin
		grp_bits = summary_q[WAW'(grp_q) * WAW'(GROUP) +: GROUP];
		sub_sel  = '0;
		for (int s = GROUP - 1; s >= 0; s--) begin
			if (grp_bits[s]) begin
				sub_sel = SAW'(s);
			end
		end
	end

	assign any_free = any_q;
	assign word_idx = WAW'({grp_q, sub_sel});

endmodule

/* design/page_bitmap_allocator.sv */
// Allocate: after the request is accepted, summary search, map read, then write with the result.
// Release: map read, then write with the result; unused action code: result with no map access.
// Init: low bound, window, then one bitmap word per cycle; the last waits for the output.
// One request at a time; the next is taken the cycle after the result is registered.
// After reset the bitmap is cleared word by word with the input not ready.
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// First-fit bitmap page allocator with used/free page counts.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
	parameter int NUM_PAGES  = 8192,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [pba_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // release_address
	input  logic [pba_pkg::ACT_W-1:0]       s_axis_tuser,  // action
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// alloc_address, out_of_memory, page_released, used_pages, free_pages, pad
	output logic [pba_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [pba_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [pba_pkg::CFG_W-1:0]       cfg_data
);
	import pba_pkg::*;

	localparam int PW        = $clog2(NUM_PAGES);
	localparam int PBL       = $clog2(PAGE_BYTES);
	localparam int CW        = PW + 1;
	localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
	localparam int WAW       = $clog2(NUM_WORDS);
	localparam int XW        = (CW > RES_W) ? CW : RES_W;
	localparam int FFW       = 33 - PBL;
	localparam int RPW       = 32 - PBL;

	state_t                state_q, state_d;
	logic [CFG_W-1:0]      kernel_end_q;
	logic [RES_W-1:0]      res_first_q;
	logic [RES_W-1:0]      res_last_q;
	logic [ACT_W-1:0]      act_q;
	logic [IN_DATA_W-1:0]  addr_q;
	logic [WAW-1:0]        wcnt_q;
	logic [WAW-1:0]        word_q;
	logic [CW-1:0]         lo_q;
	logic [XW-1:0]         a_q, b_q;
	logic                  win_q;
	logic [CW-1:0]         used_q, used_d;

	logic                  m_valid_q;
	logic [ADDR_OUT_W-1:0] out_addr_q;
	logic                  out_oom_q;
	logic                  out_rel_q;
	logic [CNT_W-1:0]      out_used_q;
	logic [CNT_W-1:0]      out_free_q;

	ram_ctl_t              ram_ctl;
	logic [WAW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;
	sum_upd_t              upd;
	logic [WAW-1:0]        upd_idx;
	logic                  find_step;
	logic                  any_free;
	logic [WAW-1:0]        word_idx;

	logic                  s_accept, out_free, emit;
	logic [ADDR_OUT_W-1:0] e_addr;
	logic                  e_oom, e_rel;
	logic [RPW-1:0]        page_rel;
	logic                  rel_in_range;
	logic [WAW-1:0]        rel_word;
	logic [BIT_W-1:0]      rel_bit;
	logic [BIT_W-1:0]      fz;
	logic [WORD_BITS-1:0]  alloc_wdata, rel_wdata, init_mask;
	logic [PW+PBL-1:0]     alloc_full;
	logic [32:0]           kend_sum;
	logic [FFW-1:0]        kend_page;
	logic [CW-1:0]         lo_d;
	logic [XW-1:0]         a_d, b_d;
	logic [CW-1:0]         ovl;
	logic                  sweep_last;

	pba_bitmap_ram #(
		.DEPTH (NUM_WORDS),
		.AW    (WAW)
	) u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pba_free_search #(
		.NUM_WORDS (NUM_WORDS),
		.WAW       (WAW)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.upd_idx  (upd_idx),
		.step     (find_step),
		.any_free (any_free),
		.word_idx (word_idx)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign page_rel     = addr_q[31:PBL];
	assign rel_in_range = {1'b0, page_rel} < FFW'(NUM_PAGES);
	assign rel_word     = page_rel[PW-1:BIT_W];
	assign rel_bit      = page_rel[BIT_W-1:0];

	always_comb begin
		fz = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!ram_rdata[i]) begin
				fz = BIT_W'(i);
			end
		end
	end

	assign alloc_wdata = ram_rdata | (WORD_BITS'(1) << fz);
	assign rel_wdata   = ram_rdata & ~(WORD_BITS'(1) << rel_bit);
	assign alloc_full  = {word_q, fz, PBL'(0)};

	assign kend_sum   = {1'b0, kernel_end_q} + 33'(PAGE_BYTES - 1);
	assign kend_page  = kend_sum[32:PBL];
	assign lo_d       = (kend_page >= FFW'(NUM_PAGES)) ? CW'(NUM_PAGES) : CW'(kend_page);
	assign a_d        = (XW'(lo_q) > XW'(res_first_q)) ? XW'(lo_q) : XW'(res_first_q);
	assign b_d        = (XW'(res_last_q) < XW'(NUM_PAGES - 1)) ? XW'(res_last_q)
	                                                              : XW'(NUM_PAGES - 1);
	assign ovl        = win_q ? CW'(b_q - a_q + XW'(1)) : '0;
	assign sweep_last = (wcnt_q == WAW'(NUM_WORDS - 1));

	always_comb begin
		logic [XW-1:0] p;
		for (int i = 0; i < WORD_BITS; i++) begin
			p = XW'({wcnt_q, BIT_W'(i)});
			init_mask[i] = (p < XW'(lo_q)) || ((p >= a_q) && (p <= b_q));
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_ctl   = '0;
		ram_waddr = wcnt_q;
		ram_wdata = '0;
		ram_raddr = word_q;
		upd       = '0;
		upd_idx   = wcnt_q;
		find_step = 1'b0;
		emit      = 1'b0;
		e_addr    = '0;
		e_oom     = 1'b0;
		e_rel     = 1'b0;
		used_d    = used_q;
		case (state_q)
			ST_CLEAR: begin
				ram_ctl.we   = 1'b1;
				upd.en       = 1'b1;
				upd.has_free = 1'b1;
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_accept) begin
					case (action_t'(s_axis_tuser))
						ACT_INIT:    state_d = ST_INIT_LO;
						ACT_ALLOC:   state_d = ST_FIND1;
						ACT_RELEASE: state_d = ST_READ;
						default:     state_d = ST_NOP;
					endcase
				end
			end
			ST_FIND1: begin
				find_step = 1'b1;
				state_d   = ST_FIND2;
			end
			ST_FIND2: begin
				if (any_free) begin
					ram_ctl.re = 1'b1;
					ram_raddr  = word_idx;
					state_d    = ST_MODIFY;
				end else begin
					state_d = ST_NOP;
				end
			end
			ST_READ: begin
				if (rel_in_range) begin
					ram_ctl.re = 1'b1;
					ram_raddr  = rel_word;
					state_d    = ST_MODIFY;
				end else begin
					state_d = ST_NOP;
				end
			end
			ST_MODIFY: begin
				if (out_free) begin
					emit      = 1'b1;
					state_d   = ST_IDLE;
					ram_waddr = word_q;
					upd_idx   = word_q;
					if (act_q == ACT_ALLOC) begin
						ram_ctl.we   = 1'b1;
						ram_wdata    = alloc_wdata;
						upd.en       = 1'b1;
						upd.has_free = ~&alloc_wdata;
						used_d       = used_q + CW'(1);
						e_addr       = ADDR_OUT_W'(alloc_full);
					end else if (ram_rdata[rel_bit]) begin
						ram_ctl.we   = 1'b1;
						ram_wdata    = rel_wdata;
						upd.en       = 1'b1;
						upd.has_free = 1'b1;
						used_d       = used_q - CW'(1);
						e_rel        = 1'b1;
					end
				end
			end
			ST_NOP: begin
				if (out_free) begin
					emit    = 1'b1;
					e_oom   = (act_q == ACT_ALLOC);
					state_d = ST_IDLE;
				end
			end
			ST_INIT_LO: begin
				state_d = ST_INIT_WIN;
			end
			ST_INIT_WIN: begin
				state_d = ST_INIT_SWEEP;
			end
			ST_INIT_SWEEP: begin
				if (!sweep_last || out_free) begin
					ram_ctl.we   = 1'b1;
					ram_wdata    = init_mask;
					upd.en       = 1'b1;
					upd.has_free = ~&init_mask;
					if (sweep_last) begin
						emit    = 1'b1;
						used_d  = lo_q + ovl;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_end_q <= '0;
			res_first_q  <= RES_FIRST_RST;
			res_last_q   <= RES_LAST_RST;
			wcnt_q       <= '0;
			used_q       <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_KERNEL_END: kernel_end_q <= cfg_data;
					REG_RES_FIRST:  res_first_q  <= cfg_data[RES_W-1:0];
					REG_RES_LAST:   res_last_q   <= cfg_data[RES_W-1:0];
					default:        ;
				endcase
			end
			if (ram_ctl.we && (state_q == ST_CLEAR || state_q == ST_INIT_SWEEP)) begin
				wcnt_q <= wcnt_q + WAW'(1);
			end
			used_q <= used_d;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			act_q  <= s_axis_tuser;
			addr_q <= s_axis_tdata;
		end
		if (ram_ctl.re) begin
			word_q <= ram_raddr;
		end
		if (state_q == ST_INIT_LO) begin
			lo_q <= lo_d;
		end
		if (state_q == ST_INIT_WIN) begin
			a_q   <= a_d;
			b_q   <= b_d;
			win_q <= (a_d <= b_d);
		end
		if (emit) begin
			out_addr_q <= e_addr;
			out_oom_q  <= e_oom;
			out_rel_q  <= e_rel;
			out_used_q <= CNT_W'(used_d);
			out_free_q <= CNT_W'(CW'(NUM_PAGES) - used_d);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, out_free_q, out_used_q, out_rel_q, out_oom_q, out_addr_q};

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(NUM_PAGES))
		else $error("used page count above map size");

	a_oom_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_oom_q) |-> (out_addr_q == '0 && out_free_q == '0 && !out_rel_q))
		else $error("out of memory result with address or free pages");

	a_release_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_rel_q) |-> (out_addr_q == '0 && !out_oom_q))
		else $error("release result carries allocate fields");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.we |-> (state_q == ST_CLEAR || state_q == ST_INIT_SWEEP
			|| state_q == ST_MODIFY))
		else $error("bitmap write outside a writing state");

endmodule

/* test/page_bitmap_allocator_tb.sv */
// ----------------------------------------------------------------------------
// page_bitmap_allocator_tb
// Stream-level check of the first-fit page allocator: a table of directed
// requests with hand-worked results, then config phases of random alloc,
// release, init and unused-code requests checked against a bitmap model,
// with random back-pressure on both sides.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_tb;
	import pba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PAGES      = 8192;
	localparam int PAGE_SHIFT     = 12;
	localparam int RANDOM_ITEMS   = 1750;
	localparam int HOLD_CYCLES    = 500;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0]      free;
		logic [CNT_W-1:0]      used;
		logic                  released;
		logic                  oom;
		logic [ADDR_OUT_W-1:0] addr;
	} page_result_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [1:0]   code;
		logic [31:0]  value;
		page_result_t res;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [ACT_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	// allocator model state
	bit          page_map [NUM_PAGES];
	int          pages_in_use;
	logic [31:0] kernel_end_cfg;
	logic [12:0] res_first_cfg;
	logic [12:0] res_last_cfg;
	int          alloc_pages [$];

	page_result_t expected_results [$];
	row_t         rows [$];
	int           errors;
	bit           calm;
	bit           hold_request;
	int           n_init, n_alloc, n_oom, n_release, n_freed, n_unused, n_phases;

	page_bitmap_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("[page_bitmap_allocator] ERROR");
		$finish;
	end

	function automatic row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.code = idx;
		r.value = val;
		return r;
	endfunction

	function automatic row_t chk_row(input logic [1:0] act, input logic [31:0] addr,
			input logic [24:0] e_addr, input logic e_oom, input logic e_rel,
			input int e_used, input int e_free);
		row_t r;
		r.kind = ROW_REQ;
		r.code = act;
		r.value = addr;
		r.res.addr = e_addr;
		r.res.oom = e_oom;
		r.res.released = e_rel;
		r.res.used = e_used[CNT_W-1:0];
		r.res.free = e_free[CNT_W-1:0];
		return r;
	endfunction

	task automatic predict_config(input logic [1:0] idx, input logic [31:0] val);
		case (idx)
			REG_KERNEL_END: kernel_end_cfg = val;
			REG_RES_FIRST:  res_first_cfg = val[12:0];
			REG_RES_LAST:   res_last_cfg = val[12:0];
			default: ;
		endcase
	endtask

	task automatic predict_page_step(input logic [1:0] act, input logic [31:0] addr,
			output page_result_t r);
		logic [32:0] kend_page;
		logic [19:0] page;
		int i;
		r = '0;
		case (act)
			ACT_INIT: begin
				n_init++;
				kend_page = ({1'b0, kernel_end_cfg} + 33'd4095) >> PAGE_SHIFT;
				pages_in_use = 0;
				for (i = 0; i < NUM_PAGES; i++) begin
					page_map[i] = (i < kend_page) || (i >= res_first_cfg && i <= res_last_cfg);
					if (page_map[i])
						pages_in_use++;
				end
			end
			ACT_ALLOC: begin
				n_alloc++;
				r.oom = 1'b1;
				for (i = 0; i < NUM_PAGES; i++) begin
					if (!page_map[i]) begin
						page_map[i] = 1'b1;
						pages_in_use++;
						r.addr = ADDR_OUT_W'(i << PAGE_SHIFT);
						r.oom = 1'b0;
						alloc_pages.push_back(i);
						if (alloc_pages.size() > 256)
							void'(alloc_pages.pop_front());
						break;
					end
				end
				if (r.oom)
					n_oom++;
			end
			ACT_RELEASE: begin
				n_release++;
				page = addr[31:PAGE_SHIFT];
				if (page < NUM_PAGES && page_map[page]) begin
					page_map[page] = 1'b0;
					pages_in_use--;
					r.released = 1'b1;
					n_freed++;
				end
			end
			default: n_unused++;
		endcase
		r.used = pages_in_use[CNT_W-1:0];
		r.free = CNT_W'(NUM_PAGES - pages_in_use);
	endtask

	task automatic send_request(input logic [1:0] act, input logic [31:0] addr,
			input bit typed, input page_result_t typed_res);
		page_result_t predicted;
		while (!calm && $urandom_range(99) < 23) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= addr;
		s_axis_tuser <= act;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		predict_page_step(act, addr, predicted);
		expected_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		predict_config(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic pick_request(output logic [1:0] act, output logic [31:0] addr);
		int r;
		int page;
		r = $urandom_range(99);
		addr = $urandom;
		if (r < 3)
			act = ACT_INIT;
		else if (r < 6)
			act = ACT_UNUSED;
		else if (r < 52)
			act = ACT_ALLOC;
		else begin
			act = ACT_RELEASE;
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					if (alloc_pages.size() != 0) begin
						page = alloc_pages[$urandom_range(alloc_pages.size() - 1)];
						addr = (page << PAGE_SHIFT) | $urandom_range(4095);
					end else
						addr = addr & 32'h01FF_FFFF;
				end
				6, 7: addr = addr & 32'h01FF_FFFF;
				8: ;
				default: addr = addr | 32'h0200_0000;
			endcase
		end
	endtask

	task automatic random_config();
		logic [31:0] kend;
		int rf, rl;
		case ($urandom_range(5))
			0: kend = 32'h0;
			1: kend = $urandom;
			2: kend = $urandom_range(32'h01FF_FFFF);
			3: kend = 32'h0200_0000 - $urandom_range(32'h0004_0000);
			4: kend = 32'hFFFF_FFFF;
			default: kend = 32'h01FF_0000 + $urandom_range(32'hFFFF);
		endcase
		case ($urandom_range(3))
			0: begin
				rf = $urandom_range(NUM_PAGES - 1);
				rl = rf + $urandom_range(63);
				if (rl > NUM_PAGES - 1)
					rl = NUM_PAGES - 1;
			end
			1: begin
				// empty window
				rl = $urandom_range(NUM_PAGES - 2);
				rf = rl + 1 + $urandom_range(NUM_PAGES - 2 - rl);
			end
			2: begin
				rf = 0;
				rl = NUM_PAGES - 1;
			end
			default: begin
				rf = $urandom_range(NUM_PAGES - 1);
				rl = $urandom_range(NUM_PAGES - 1);
			end
		endcase
		write_register(REG_KERNEL_END, kend);
		write_register(REG_RES_FIRST, {19'($urandom_range(32'h7FFFF)), rf[12:0]});
		write_register(REG_RES_LAST, {19'($urandom_range(32'h7FFFF)), rl[12:0]});
		if ($urandom_range(3) == 0)
			write_register(REG_UNUSED, $urandom);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result(input page_result_t got);
		page_result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result with none pending, actual %h", $time, got);
			errors++;
		end else begin
			want = expected_results.pop_front();
			check_field("alloc_address", 32'(want.addr), 32'(got.addr));
			check_field("out_of_memory", 32'(want.oom), 32'(got.oom));
			check_field("page_released", 32'(want.released), 32'(got.released));
			check_field("used_pages", 32'(want.used), 32'(got.used));
			check_field("free_pages", 32'(want.free), 32'(got.free));
		end
	endtask

	// result side: checks and back-pressure
	always @(posedge clk) begin
		int hold_left;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
			check_result(m_axis_tdata[$bits(page_result_t)-1:0]);
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= calm || ($urandom_range(99) >= 23);
	end

	initial begin
		logic [1:0]  act;
		logic [31:0] addr;
		int n_random, phase_len, j;
		bit hold_done, pause_done;

		kernel_end_cfg = 32'h0;
		res_first_cfg = RES_FIRST_RST;
		res_last_cfg = RES_LAST_RST;

		// reset map: every page free, window 160..191
		rows.push_back(chk_row(ACT_ALLOC,   32'h0000_0000, 25'h0000000, 0, 0, 1, 8191));
		rows.push_back(chk_row(ACT_ALLOC,   32'h0000_0000, 25'h0001000, 0, 0, 2, 8190));
		rows.push_back(chk_row(ACT_RELEASE, 32'h0000_0FFF, 25'h0000000, 0, 1, 1, 8191));
		rows.push_back(chk_row(ACT_RELEASE, 32'h0000_0000, 25'h0000000, 0, 0, 1, 8191));
		rows.push_back(chk_row(ACT_RELEASE, 32'hFFFF_FFFF, 25'h0000000, 0, 0, 1, 8191));
		rows.push_back(chk_row(ACT_RELEASE, 32'h0200_0000, 25'h0000000, 0, 0, 1, 8191));
		rows.push_back(chk_row(ACT_UNUSED,  32'hFFFF_FFFF, 25'h0000000, 0, 0, 1, 8191));
		rows.push_back(chk_row(ACT_INIT,    32'h0000_0000, 25'h0000000, 0, 0, 32, 8160));
		rows.push_back(chk_row(ACT_ALLOC,   32'h0000_0000, 25'h0000000, 0, 0, 33, 8159));
		rows.push_back(chk_row(ACT_RELEASE, 32'h01FF_F000, 25'h0000000, 0, 0, 33, 8159));
		rows.push_back(chk_row(ACT_ALLOC,   32'h0000_0000, 25'h0001000, 0, 0, 34, 8158));
		rows.push_back(chk_row(ACT_RELEASE, 32'h000A_0000, 25'h0000000, 0, 1, 33, 8159));
		rows.push_back(chk_row(ACT_ALLOC,   32'h0000_0000, 25'h0002000, 0, 0, 34, 8158));
		// write to an unknown index must change nothing
		rows.push_back(cfg_row(REG_UNUSED, 32'hFFFF_FFFF));
		rows.push_back(chk_row(ACT_INIT,    32'h0000_0000, 25'h0000000, 0, 0, 32, 8160));
		// round-up sum needs the 33rd bit
		rows.push_back(cfg_row(REG_KERNEL_END, 32'hFFFF_FFFF));
		rows.push_back(chk_row(ACT_INIT,    32'h0000_0000, 25'h0000000, 0, 0, 8192, 0));
		rows.push_back(chk_row(ACT_ALLOC,   32'h0000_0000, 25'h0000000, 1, 0, 8192, 0));
		rows.push_back(chk_row(ACT_RELEASE, 32'h01FF_FFFF, 25'h0000000, 0, 1, 8191, 1));
		rows.push_back(chk_row(ACT_ALLOC,   32'h0000_0000, 25'h1FFF000, 0, 0, 8192, 0));
		// kernel end exactly at the top of the map, empty window
		rows.push_back(cfg_row(REG_KERNEL_END, 32'h0200_0000));
		rows.push_back(cfg_row(REG_RES_FIRST, 32'h0000_0005));
		rows.push_back(cfg_row(REG_RES_LAST, 32'h0000_0004));
		rows.push_back(chk_row(ACT_INIT,    32'h0000_0000, 25'h0000000, 0, 0, 8192, 0));
		rows.push_back(cfg_row(REG_KERNEL_END, 32'h0000_1001));
		rows.push_back(chk_row(ACT_INIT,    32'h0000_0000, 25'h0000000, 0, 0, 2, 8190));
		rows.push_back(chk_row(ACT_ALLOC,   32'h0000_0000, 25'h0002000, 0, 0, 3, 8189));
		// window spanning the whole map, then a single top page
		rows.push_back(cfg_row(REG_KERNEL_END, 32'h0000_0000));
		rows.push_back(cfg_row(REG_RES_FIRST, 32'h0000_0000));
		rows.push_back(cfg_row(REG_RES_LAST, 32'h0000_1FFF));
		rows.push_back(chk_row(ACT_INIT,    32'h0000_0000, 25'h0000000, 0, 0, 8192, 0));
		rows.push_back(cfg_row(REG_RES_FIRST, 32'h0000_1FFF));
		rows.push_back(chk_row(ACT_INIT,    32'h0000_0000, 25'h0000000, 0, 0, 1, 8191));
		rows.push_back(chk_row(ACT_ALLOC,   32'h0000_0000, 25'h0000000, 0, 0, 2, 8190));
		rows.push_back(chk_row(ACT_RELEASE, 32'h01FF_FABC, 25'h0000000, 0, 1, 1, 8191));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// map clearing pass after reset
		do @(posedge clk); while (s_axis_tready !== 1'b1);

		foreach (rows[k]) begin
			if (rows[k].kind == ROW_CFG) begin
				drain();
				write_register(rows[k].code, rows[k].value);
			end else
				send_request(rows[k].code, rows[k].value, 1'b1, rows[k].res);
		end

		n_random = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		while (n_random < RANDOM_ITEMS) begin
			drain();
			random_config();
			n_phases++;
			send_request(ACT_INIT, $urandom, 1'b0, '0);
			n_random++;
			phase_len = $urandom_range(40, 100);
			for (j = 0; j < phase_len && n_random < RANDOM_ITEMS; j++) begin
				calm = (n_random >= 400 && n_random < 650);
				if (!hold_done && n_random >= 900) begin
					hold_done = 1'b1;
					hold_request = 1'b1;
				end
				if (!pause_done && n_random >= 1300) begin
					pause_done = 1'b1;
					drain();
				end
				pick_request(act, addr);
				send_request(act, addr, 1'b0, '0);
				n_random++;
			end
		end
		calm = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		$display("Ran %0d config phases: %0d init, %0d alloc (%0d out of memory),",
			n_phases, n_init, n_alloc, n_oom);
		$display("  %0d release (%0d freed, rest ignored), %0d unused-code requests",
			n_release, n_freed, n_unused);
		if (errors == 0 && expected_results.size() == 0)
			$display("[page_bitmap_allocator] OK");
		else
			$display("[page_bitmap_allocator] ERROR");
		$finish;
	end

endmodule
